// ===== hw/rtl/exp3_pkg.sv =====
// ----------------------------------------------------------------------------
// exp3_pkg
// Shared constants, widths and codes for the Exp3 arm selector.
// ----------------------------------------------------------------------------
package exp3_pkg;

  // Arm array size and derived widths
  localparam int MAX_ARMS = 8;
  localparam int ARM_W    = $clog2(MAX_ARMS);
  localparam int K_W      = $clog2(MAX_ARMS + 1);
  localparam int Q_W      = 17;
  localparam int WSUM_W   = 32 + ARM_W;
  localparam int CUM_W    = Q_W + ARM_W;

  // Shared divider and multiplier widths
  localparam int DNUM_W   = 50;
  localparam int DDEN_W   = WSUM_W;
  localparam int DCNT_W   = $clog2(DNUM_W + 1);
  localparam int MA_W     = 33;
  localparam int MB_W     = 18;
  localparam int PROD_W   = MA_W + MB_W;

  localparam logic [Q_W-1:0] ONE_Q16   = 17'h10000;
  localparam logic [Q_W-1:0] PROB_INIT = Q_W'(65536 / MAX_ARMS);
  localparam logic [31:0]    W_INIT    = 32'h0001_0000;
  localparam logic [2:0]     EXP_TERMS = 3'd7;

  // Request types
  localparam logic REQ_SELECT = 1'b0;
  localparam logic REQ_UPDATE = 1'b1;

  // Result status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_BAD_ARM = 2'd1;
  localparam logic [1:0] ST_ZERO_P  = 2'd2;

  // Configuration register indexes
  localparam logic CFG_GAMMA = 1'b0;
  localparam logic CFG_ARMS  = 1'b1;

  typedef logic [31:0]    weight_t;
  typedef logic [Q_W-1:0] prob_t;

endpackage

// ===== hw/rtl/exp3_div.sv =====
// ----------------------------------------------------------------------------
// exp3_div
// Restoring divider, one quotient bit per cycle, shared by all divisions.
// ----------------------------------------------------------------------------
module exp3_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [exp3_pkg::DNUM_W-1:0] num,
  input  logic [exp3_pkg::DDEN_W-1:0] den,
  output logic                        done,
  output logic [exp3_pkg::DNUM_W-1:0] quot
);

  logic                        busy;
  logic [exp3_pkg::DCNT_W-1:0] cnt;
  logic [exp3_pkg::DDEN_W-1:0] rem;
  logic [exp3_pkg::DNUM_W-1:0] q;
  logic [exp3_pkg::DDEN_W:0]   shifted;
  logic                        fits;

  // One subtract/compare step
  assign shifted = {rem, q[exp3_pkg::DNUM_W-1]};
  assign fits    = shifted >= {1'b0, den};
  assign quot    = q;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      // Pulse after the last quotient bit
      done <= busy && !start && (cnt == exp3_pkg::DCNT_W'(1));
      if (start) begin
        busy <= 1'b1;
        cnt  <= exp3_pkg::DCNT_W'(exp3_pkg::DNUM_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == exp3_pkg::DCNT_W'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  // Remainder and quotient shift register
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      q   <= num;
    end else if (busy) begin
      rem <= fits ? exp3_pkg::DDEN_W'(shifted - {1'b0, den})
                  : shifted[exp3_pkg::DDEN_W-1:0];
      q   <= {q[exp3_pkg::DNUM_W-2:0], fits};
    end
  end

endmodule

// ===== hw/rtl/exp3_bandit_arm_selector.sv =====
// ----------------------------------------------------------------------------
// exp3_bandit_arm_selector
// Exp3 arm selector: sequencer around one shared multiplier and one
// shared bit-serial divider.
// ----------------------------------------------------------------------------
// Select visits every arm slot, active or not; an update halves all weights while
// the new weight is too large, and ends early for a bad arm or zero prob.
// Each division holds the shared 50-step divider. One item in flight; the next beat
// is taken while a result still waits on the output.
// Reset (rst, synchronous) loads weights to 1.0, probabilities to 1/MAX_ARMS,
// gamma 6554 and arm count 8; no clearing pass is needed.
// ----------------------------------------------------------------------------
module exp3_bandit_arm_selector (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        req_type,
  input  logic [15:0] random_draw,
  input  logic [2:0]  arm_index,
  input  logic [16:0] reward,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  chosen_arm,
  output logic [1:0]  status,
  input  logic        cfg_wr_en,
  input  logic        cfg_index,
  input  logic [16:0] cfg_data
);

  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_SUM    = 5'd1;
  localparam logic [4:0] S_EXPL   = 5'd2;
  localparam logic [4:0] S_PARM   = 5'd3;
  localparam logic [4:0] S_PMUL   = 5'd4;
  localparam logic [4:0] S_PDIV   = 5'd5;
  localparam logic [4:0] S_STORE  = 5'd6;
  localparam logic [4:0] S_SELFIN = 5'd7;
  localparam logic [4:0] S_UCHK   = 5'd8;
  localparam logic [4:0] S_EST    = 5'd9;
  localparam logic [4:0] S_EMUL   = 5'd10;
  localparam logic [4:0] S_EDIV   = 5'd11;
  localparam logic [4:0] S_TMUL   = 5'd12;
  localparam logic [4:0] S_TDIV   = 5'd13;
  localparam logic [4:0] S_WMUL   = 5'd14;
  localparam logic [4:0] S_WNEW   = 5'd15;
  localparam logic [4:0] S_HALVE  = 5'd16;
  localparam logic [4:0] S_UFIN   = 5'd17;

  localparam int ARM_W = exp3_pkg::ARM_W;
  localparam int K_W   = exp3_pkg::K_W;
  localparam int Q_W   = exp3_pkg::Q_W;

  // Configuration
  logic [16:0] gamma_reg;
  logic [3:0]  arms_reg;

  // Arm state
  exp3_pkg::weight_t w    [exp3_pkg::MAX_ARMS];
  exp3_pkg::prob_t   prob [exp3_pkg::MAX_ARMS];

  // Sequencer and working registers
  logic [4:0]                  state;
  logic [ARM_W-1:0]            i;
  logic [15:0]                 draw;
  logic [Q_W-1:0]              r_sat;
  logic                        arm_bad;
  logic [exp3_pkg::WSUM_W-1:0] wsum;
  logic [Q_W-1:0]              explore;
  logic [Q_W-1:0]              p_cur;
  logic [exp3_pkg::CUM_W-1:0]  cum;
  logic [exp3_pkg::CUM_W-1:0]  cum_next;
  logic                        found;
  logic                        anynz;
  logic [ARM_W-1:0]            pick;
  logic [ARM_W-1:0]            lastnz;
  logic [32:0]                 est;
  logic [Q_W-1:0]              e;
  logic [Q_W-1:0]              term;
  logic [17:0]                 esum;
  logic [2:0]                  n;
  logic [34:0]                 nw;
  logic [1:0]                  st_res;
  logic [ARM_W-1:0]            sel_res;

  // Effective configuration
  logic [Q_W-1:0] g_eff;
  logic [K_W-1:0] k_eff;
  logic           i_active;

  // Shared multiplier
  logic [exp3_pkg::MA_W-1:0]   mul_a;
  logic [exp3_pkg::MB_W-1:0]   mul_b;
  logic [exp3_pkg::PROD_W-1:0] prod;

  // Shared divider
  logic                        div_start;
  logic                        div_start_next;
  logic                        div_done;
  logic [exp3_pkg::DNUM_W-1:0] div_num;
  logic [exp3_pkg::DDEN_W-1:0] div_den;
  logic [exp3_pkg::DNUM_W-1:0] div_quot;

  logic [Q_W:0]   psum;
  logic [exp3_pkg::MAX_ARMS-1:0] w_msb;

  assign g_eff = (gamma_reg > 17'(exp3_pkg::ONE_Q16)) ? exp3_pkg::ONE_Q16 : gamma_reg;

  always_comb begin
    if (arms_reg == 4'd0) begin
      k_eff = K_W'(1);
    end else if (32'(arms_reg) > exp3_pkg::MAX_ARMS) begin
      k_eff = K_W'(exp3_pkg::MAX_ARMS);
    end else begin
      k_eff = K_W'(arms_reg);
    end
  end

  assign i_active = K_W'(i) < k_eff;
  assign in_ready = state == S_IDLE;
  assign cum_next = cum + exp3_pkg::CUM_W'(p_cur);
  assign psum     = {1'b0, div_quot[Q_W-1:0]} + {1'b0, explore};

  // Multiplier operand select
  always_comb begin
    unique case (state)
      S_PMUL: begin
        mul_a = exp3_pkg::MA_W'(w[i]);
        mul_b = exp3_pkg::MB_W'(exp3_pkg::ONE_Q16 - g_eff);
      end
      S_EMUL: begin
        mul_a = est;
        mul_b = exp3_pkg::MB_W'(g_eff);
      end
      S_TMUL: begin
        mul_a = exp3_pkg::MA_W'(term);
        mul_b = exp3_pkg::MB_W'(e);
      end
      S_WMUL: begin
        mul_a = exp3_pkg::MA_W'(w[i]);
        mul_b = esum;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  // Divider operand select, held through each wait state
  always_comb begin
    unique case (state)
      S_EXPL: begin
        div_num = exp3_pkg::DNUM_W'((wsum == '0) ? exp3_pkg::ONE_Q16 : g_eff);
        div_den = exp3_pkg::DDEN_W'(k_eff);
      end
      S_PDIV: begin
        div_num = prod[exp3_pkg::DNUM_W-1:0];
        div_den = wsum;
      end
      S_EST: begin
        div_num = exp3_pkg::DNUM_W'({r_sat, 16'd0});
        div_den = exp3_pkg::DDEN_W'(prob[i]);
      end
      S_EDIV: begin
        div_num = exp3_pkg::DNUM_W'(prod[exp3_pkg::PROD_W-1:16]);
        div_den = exp3_pkg::DDEN_W'(k_eff);
      end
      S_TDIV: begin
        div_num = exp3_pkg::DNUM_W'(prod[exp3_pkg::PROD_W-1:16]);
        div_den = exp3_pkg::DDEN_W'(n);
      end
      default: begin
        div_num = '0;
        div_den = '0;
      end
    endcase
  end

  // Divider start, raised as the sequencer enters a wait state
  always_comb begin
    unique case (state) inside
      S_SUM:                  div_start_next = i == ARM_W'(exp3_pkg::MAX_ARMS - 1);
      S_UCHK:                 div_start_next = !arm_bad && prob[i] != '0;
      S_PMUL, S_EMUL, S_TMUL: div_start_next = 1'b1;
      default:                div_start_next = 1'b0;
    endcase
  end

  exp3_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quot  (div_quot)
  );

  // Selection result: the covering arm, else the last nonzero-probability arm, else the last active arm
  always_comb begin
    if (found) begin
      sel_res = pick;
    end else if (anynz) begin
      sel_res = lastnz;
    end else begin
      sel_res = ARM_W'(k_eff - 1'b1);
    end
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      gamma_reg <= 17'd6554;
      arms_reg  <= 4'd8;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        exp3_pkg::CFG_GAMMA: gamma_reg <= cfg_data;
        exp3_pkg::CFG_ARMS:  arms_reg  <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      div_start <= 1'b0;
      out_valid <= 1'b0;
      for (int a = 0; a < exp3_pkg::MAX_ARMS; a++) begin
        w[a]    <= exp3_pkg::W_INIT;
        prob[a] <= exp3_pkg::PROB_INIT;
      end
    end else begin
      div_start <= div_start_next;
      // Result taken; the finish states refill the register themselves
      if (out_valid && out_ready && state != S_SELFIN && state != S_UFIN) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            draw      <= random_draw;
            r_sat     <= (reward > exp3_pkg::ONE_Q16) ? exp3_pkg::ONE_Q16 : reward;
            arm_bad   <= 32'(arm_index) >= 32'(k_eff);
            wsum      <= '0;
            cum       <= '0;
            found     <= 1'b0;
            anynz     <= 1'b0;
            pick      <= '0;
            lastnz    <= '0;
            st_res    <= exp3_pkg::ST_OK;
            if (req_type == exp3_pkg::REQ_UPDATE) begin
              i     <= ARM_W'(arm_index);
              state <= S_UCHK;
            end else begin
              i     <= '0;
              state <= S_SUM;
            end
          end
        end
        // Total weight over active arms
        S_SUM: begin
          if (i_active) begin
            wsum <= wsum + exp3_pkg::WSUM_W'(w[i]);
          end
          if (i == ARM_W'(exp3_pkg::MAX_ARMS - 1)) begin
            i     <= '0;
            state <= S_EXPL;
          end else begin
            i <= i + 1'b1;
          end
        end
        // g/K, or 1/K when total weight is zero
        S_EXPL: begin
          if (div_done) begin
            explore <= div_quot[Q_W-1:0];
            state   <= S_PARM;
          end
        end
        S_PARM: begin
          if (!i_active) begin
            p_cur <= '0;
            state <= S_STORE;
          end else if (wsum == '0) begin
            p_cur <= explore;
            state <= S_STORE;
          end else begin
            state <= S_PMUL;
          end
        end
        S_PMUL: begin
          state <= S_PDIV;
        end
        S_PDIV: begin
          if (div_done) begin
            p_cur <= (psum > {1'b0, exp3_pkg::ONE_Q16}) ? exp3_pkg::ONE_Q16
                                                         : psum[Q_W-1:0];
            state <= S_STORE;
          end
        end
        // Store probability and walk the running sum
        S_STORE: begin
          prob[i] <= p_cur;
          if (i_active) begin
            cum <= cum_next;
            if (!found && cum_next > exp3_pkg::CUM_W'(draw)) begin
              found <= 1'b1;
              pick  <= i;
            end
            if (p_cur != '0) begin
              anynz  <= 1'b1;
              lastnz <= i;
            end
          end
          if (i == ARM_W'(exp3_pkg::MAX_ARMS - 1)) begin
            state <= S_SELFIN;
          end else begin
            i     <= i + 1'b1;
            state <= S_PARM;
          end
        end
        S_SELFIN: begin
          if (!out_valid || out_ready) begin
            out_valid  <= 1'b1;
            chosen_arm <= 3'(sel_res);
            status     <= exp3_pkg::ST_OK;
            state      <= S_IDLE;
          end
        end
        // Update checks
        S_UCHK: begin
          if (arm_bad) begin
            st_res <= exp3_pkg::ST_BAD_ARM;
            state  <= S_UFIN;
          end else if (prob[i] == '0) begin
            st_res <= exp3_pkg::ST_ZERO_P;
            state  <= S_UFIN;
          end else begin
            state <= S_EST;
          end
        end
        // Importance-weighted reward r/p
        S_EST: begin
          if (div_done) begin
            est   <= div_quot[32:0];
            state <= S_EMUL;
          end
        end
        S_EMUL: begin
          state <= S_EDIV;
        end
        // Exponent, saturated at 1.0
        S_EDIV: begin
          if (div_done) begin
            e     <= (div_quot > exp3_pkg::DNUM_W'(exp3_pkg::ONE_Q16))
                     ? exp3_pkg::ONE_Q16 : div_quot[Q_W-1:0];
            term  <= exp3_pkg::ONE_Q16;
            esum  <= 18'(exp3_pkg::ONE_Q16);
            n     <= 3'd1;
            state <= S_TMUL;
          end
        end
        // Taylor series terms
        S_TMUL: begin
          state <= S_TDIV;
        end
        S_TDIV: begin
          if (div_done) begin
            term <= div_quot[Q_W-1:0];
            esum <= esum + 18'(div_quot[Q_W-1:0]);
            if (n == exp3_pkg::EXP_TERMS) begin
              state <= S_WMUL;
            end else begin
              n     <= n + 1'b1;
              state <= S_TMUL;
            end
          end
        end
        S_WMUL: begin
          state <= S_WNEW;
        end
        S_WNEW: begin
          nw    <= prod[50:16];
          state <= S_HALVE;
        end
        // Halve everything until the new weight fits below 2^31
        S_HALVE: begin
          if (nw[34:31] != 4'd0) begin
            for (int a = 0; a < exp3_pkg::MAX_ARMS; a++) begin
              w[a] <= w[a] >> 1;
            end
            nw <= nw >> 1;
          end else begin
            w[i]   <= nw[31:0];
            st_res <= exp3_pkg::ST_OK;
            state  <= S_UFIN;
          end
        end
        S_UFIN: begin
          if (!out_valid || out_ready) begin
            out_valid  <= 1'b1;
            chosen_arm <= 3'd0;
            status     <= st_res;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_comb begin
    for (int a = 0; a < exp3_pkg::MAX_ARMS; a++) begin
      w_msb[a] = w[a][31];
    end
  end

  // Divider results only arrive where the sequencer waits for one
  a_div_done_waits: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == S_EXPL || state == S_PDIV || state == S_EST ||
                  state == S_EDIV || state == S_TDIV))
    else $error("divider result outside a wait state");

  // Weights stay below 2^31
  a_weight_range: assert property (@(posedge clk) disable iff (rst)
    w_msb == '0)
    else $error("weight reached 2^31");

  // Halving ends once the new weight fits
  a_halve_exit: assert property (@(posedge clk) disable iff (rst)
    (state == S_HALVE && nw[34:31] == 4'd0) |=> state == S_UFIN)
    else $error("halving did not finish");

  // Non-ok status only on update results, which carry arm zero
  a_status_arm: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != exp3_pkg::ST_OK) |-> chosen_arm == 3'd0)
    else $error("error status with nonzero arm");

endmodule
